>>> hw/rtl/ptt_pkg.sv
// Shared constants, command codes and types for the priority task table.
package ptt_pkg;

  localparam int TASK_SLOTS = 256;
  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int ID_W = 8;
  localparam int USER_W = 16;
  localparam int PRIO_W = 32;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_EDIT = 2'd1;
  localparam logic [1:0] CMD_REM  = 2'd2;
  localparam logic [1:0] CMD_EXEC = 2'd3;

  typedef struct packed {
    logic              any;
    logic [SLOT_W-1:0] idx;
    logic [USER_W-1:0] user;
  } best_t;

endpackage

>>> hw/rtl/priority_task_table.sv
// Priority task table: add, edit, remove and execute-top over TASK_SLOTS slots.
// Add, edit and remove are accepted while idle and give no result; busy stays low.
// Execute-top scans the priority RAM one slot per cycle, then passes a drain state
// before the result strobe; the next command can be accepted in the cycle after it.
// Results cannot be stalled. Reset clears all valid marks at once; RAM contents stay.
module priority_task_table
  import ptt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [ID_W-1:0]   task_id,
  input  logic [USER_W-1:0] user_id,
  input  logic [PRIO_W-1:0] priority_req,
  output logic              done,
  output logic              found,
  output logic [USER_W-1:0] owner_user
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [TASK_SLOTS-1:0] entry_valid;
  logic [SLOT_W-1:0]     rd_cnt;
  logic                  chk_v;
  logic                  chk_vld;
  logic [SLOT_W-1:0]     chk_idx;
  logic                  accept;
  logic                  in_range;
  logic [SLOT_W-1:0]     slot;
  logic                  we_user;
  logic                  we_prio;
  logic [USER_W-1:0]     rd_user;
  logic [PRIO_W-1:0]     rd_prio;
  best_t                 best;

  assign accept   = start && !busy;
  assign in_range = 32'(task_id) < 32'(TASK_SLOTS);
  assign slot     = SLOT_W'(task_id);
  assign we_user  = accept && command == CMD_ADD && in_range;
  // The priority of an absent slot is never used, and add rewrites it as the slot
  // becomes valid, so an edit may write it unconditionally.
  assign we_prio  = we_user || (accept && command == CMD_EDIT && in_range);

  assign busy       = state != S_IDLE;
  assign done       = state == S_RESULT;
  assign found      = best.any;
  assign owner_user = best.any ? best.user : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && command == CMD_EXEC) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt == SLOT_W'(TASK_SLOTS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_RESULT;
      S_RESULT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      chk_v       <= 1'b0;
      rd_cnt      <= '0;
    end else begin
      state <= state_next;
      chk_v <= state == S_SCAN;
      if (state == S_SCAN) begin
        rd_cnt <= rd_cnt + SLOT_W'(1);
      end else begin
        rd_cnt <= '0;
      end
      if (we_user) begin
        entry_valid[slot] <= 1'b1;
      end else if (accept && command == CMD_REM && in_range) begin
        entry_valid[slot] <= 1'b0;
      end
      if (state == S_RESULT && best.any) begin
        entry_valid[best.idx] <= 1'b0;
      end
    end
    chk_idx <= rd_cnt;
    chk_vld <= entry_valid[rd_cnt];
  end

  ptt_ram #(
    .WIDTH(USER_W),
    .DEPTH(TASK_SLOTS)
  ) u_user_ram (
    .clk  (clk),
    .we   (we_user),
    .waddr(slot),
    .wdata(user_id),
    .raddr(rd_cnt),
    .rdata(rd_user)
  );

  ptt_ram #(
    .WIDTH(PRIO_W),
    .DEPTH(TASK_SLOTS)
  ) u_prio_ram (
    .clk  (clk),
    .we   (we_prio),
    .waddr(slot),
    .wdata(priority_req),
    .raddr(rd_cnt),
    .rdata(rd_prio)
  );

  ptt_best u_best (
    .clk   (clk),
    .rst   (rst),
    .clear (accept && command == CMD_EXEC),
    .sample(chk_v && chk_vld),
    .prio  (rd_prio),
    .user  (rd_user),
    .idx   (chk_idx),
    .best  (best)
  );

endmodule

>>> hw/rtl/ptt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ptt_best.sv
// Running maximum over scanned slots; ties go to the later, larger slot index.
module ptt_best
  import ptt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              sample,
  input  logic [PRIO_W-1:0] prio,
  input  logic [USER_W-1:0] user,
  input  logic [SLOT_W-1:0] idx,
  output best_t             best
);

  logic [PRIO_W-1:0] best_prio;
  logic              take;

  assign take = sample && (!best.any || prio >= best_prio);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.any <= 1'b0;
    end else if (take) begin
      best.any <= 1'b1;
    end
    if (take) begin
      best_prio <= prio;
      best.idx  <= idx;
      best.user <= user;
    end
  end

endmodule

>>> hw/rtl/ptt_checker.sv
// Port-level checks on command transfers and results of the priority task table.
module ptt_checker
  import ptt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        command,
  input logic              done,
  input logic              found,
  input logic [USER_W-1:0] owner_user
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("Result shown while the table is not busy.");

  a_empty_user: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> owner_user == '0)
    else $error("Owner user is not zero for an empty table.");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("Table still busy after a result.");

  a_exec_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_EXEC) |=> (busy && !done))
    else $error("Execute-top transfer did not start a scan.");

  a_cmd_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command != CMD_EXEC) |=> (!busy && !done))
    else $error("Table command caused a result or a busy cycle.");

endmodule

bind priority_task_table ptt_checker u_ptt_checker (.*);
